// ----- hw/rtl/nfba_pkg.sv -----
// Shared types and constants for the next-fit block allocator.
// No dependencies; imported by every allocator module.
package nfba_pkg;

    localparam int ARENA_BYTES = 65536;
    localparam int MAX_BLOCKS  = 256;
    localparam int PAGE_BYTES  = 4096;
    localparam int HDR_BYTES   = 16;

    localparam int ADDR_W  = 16;
    localparam int SIZE_W  = 16;
    localparam int OP_W    = 2;
    localparam int ST_W    = 2;
    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int CNT_W   = IDX_W + 1;
    localparam int START_W = $clog2(ARENA_BYTES);
    localparam int HEAP_W  = START_W + 1;
    localparam int NEED_W  = SIZE_W + 1;
    localparam int BRK_W   = ((HEAP_W > NEED_W) ? HEAP_W : NEED_W) + 2;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_RESET = 2'd2;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_ARENA   = 2'd1;
    localparam logic [ST_W-1:0] ST_TABLE   = 2'd2;
    localparam logic [ST_W-1:0] ST_UNKNOWN = 2'd3;

    typedef struct packed {
        logic               used;
        logic [SIZE_W-1:0]  size;
        logic [START_W-1:0] start;
    } blk_t;

    typedef struct packed {
        logic load;
        logic start_alloc;
        logic start_free;
        logic rd;
        logic next;
        logic take;
        logic release_blk;
        logic grow;
        logic append;
        logic clear_heap;
        logic res_ok;
        logic res_unknown;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            in_range;
        logic            fit;
        logic            match;
        logic            out_free;
    } sts_t;

endpackage

// ----- hw/rtl/next_fit_block_allocator.sv -----
// Next-fit block allocator top level: one request in, one result out per request.
// Reset and unused ops return a result directly; allocate scans the block table from the rover,
// appending a new block when none fits, and free scans from the first block up to the match
// or, when the address is unknown, to the end of the table.
// One request at a time: s_ready returns in the cycle after the result loads, which waits while
// the previous result is held. Synchronous active-low reset empties the heap at once.
module next_fit_block_allocator import nfba_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_op,
    input  logic [SIZE_W-1:0] s_num_bytes,
    input  logic [ADDR_W-1:0] s_free_address,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ADDR_W-1:0] m_data_address,
    output logic [ST_W-1:0]   m_status
);

    cmd_t cmd;
    sts_t sts;

    nfba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    nfba_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_op           (s_op),
        .s_num_bytes    (s_num_bytes),
        .s_free_address (s_free_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data_address (m_data_address),
        .m_status       (m_status)
    );

endmodule

// ----- hw/rtl/nfba_datapath.sv -----
// Allocator datapath: block table memory, heap registers, scan index and result register.
// Depends on nfba_pkg; driven by nfba_ctrl through cmd_t, reports through sts_t.
module nfba_datapath import nfba_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic [OP_W-1:0]   s_op,
    input  logic [SIZE_W-1:0] s_num_bytes,
    input  logic [ADDR_W-1:0] s_free_address,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ADDR_W-1:0] m_data_address,
    output logic [ST_W-1:0]   m_status
);

    blk_t mem [MAX_BLOCKS];

    logic [OP_W-1:0]   op_reg;
    logic [SIZE_W-1:0] req_reg;
    logic [ADDR_W-1:0] faddr_reg;
    blk_t              rd_data_reg;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  rover_reg, rover_next;
    logic [HEAP_W-1:0] heap_reg, heap_next;
    logic [HEAP_W-1:0] break_reg, break_next;
    logic [BRK_W-1:0]  new_break_reg;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [ST_W-1:0]   res_status_reg, res_status_next;
    logic              m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0] m_data_address_reg;
    logic [ST_W-1:0]   m_status_reg;

    logic              table_full;
    logic              arena_over;
    logic              append_ok;
    logic              mem_we;
    logic [IDX_W-1:0]  wr_addr;
    blk_t              wr_data;
    logic [BRK_W-1:0]  need;
    logic [BRK_W-1:0]  room;
    logic [BRK_W-1:0]  grow;
    logic [HEAP_W-1:0] rd_start_ext;
    logic [HEAP_W-1:0] heap_data;

    assign rd_start_ext = {1'b0, rd_data_reg.start} + HEAP_W'(HDR_BYTES);
    assign heap_data    = heap_reg + HEAP_W'(HDR_BYTES);

    assign sts.op       = op_reg;
    assign sts.in_range = (idx_reg < count_reg);
    assign sts.fit      = !rd_data_reg.used && (rd_data_reg.size >= req_reg);
    assign sts.match    = (rd_start_ext == {1'b0, faddr_reg});
    assign sts.out_free = !m_valid_reg || m_ready;

    assign need = BRK_W'(req_reg) + BRK_W'(2 * HDR_BYTES);
    assign room = BRK_W'(break_reg) - BRK_W'(heap_reg);
    assign grow = ((need >> PAGE_SHIFT) + BRK_W'(1)) << PAGE_SHIFT;

    assign table_full = (count_reg == CNT_W'(MAX_BLOCKS));
    assign arena_over = (new_break_reg > BRK_W'(ARENA_BYTES));
    assign append_ok  = cmd.append && !table_full && !arena_over;

    always_comb begin
        mem_we  = cmd.take || cmd.release_blk || append_ok;
        wr_addr = idx_reg[IDX_W-1:0];
        wr_data = rd_data_reg;
        if (cmd.take) begin
            wr_data.used = 1'b1;
        end else if (cmd.release_blk) begin
            wr_data.used = 1'b0;
        end else begin
            wr_addr       = count_reg[IDX_W-1:0];
            wr_data.used  = 1'b1;
            wr_data.size  = req_reg;
            wr_data.start = heap_reg[START_W-1:0];
        end
    end

    always_comb begin
        idx_next        = idx_reg;
        count_next      = count_reg;
        rover_next      = rover_reg;
        heap_next       = heap_reg;
        break_next      = break_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;

        if (cmd.start_alloc) begin
            idx_next = CNT_W'(rover_reg);
        end
        if (cmd.start_free) begin
            idx_next = '0;
        end
        if (cmd.next) begin
            idx_next = idx_reg + CNT_W'(1);
        end
        if (cmd.take) begin
            rover_next      = idx_reg[IDX_W-1:0];
            res_addr_next   = rd_start_ext[ADDR_W-1:0];
            res_status_next = ST_OK;
        end
        if (cmd.release_blk || cmd.res_ok) begin
            res_addr_next   = '0;
            res_status_next = ST_OK;
        end
        if (cmd.res_unknown) begin
            res_addr_next   = '0;
            res_status_next = ST_UNKNOWN;
        end
        if (cmd.append) begin
            if (table_full) begin
                res_addr_next   = '0;
                res_status_next = ST_TABLE;
            end else if (arena_over) begin
                res_addr_next   = '0;
                res_status_next = ST_ARENA;
            end else begin
                break_next      = new_break_reg[HEAP_W-1:0];
                rover_next      = '0;
                count_next      = count_reg + CNT_W'(1);
                res_addr_next   = heap_data[ADDR_W-1:0];
                res_status_next = ST_OK;
                heap_next       = heap_data + HEAP_W'(req_reg);
            end
        end
        if (cmd.clear_heap) begin
            count_next = '0;
            rover_next = '0;
            heap_next  = '0;
            break_next = '0;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            rover_reg   <= '0;
            heap_reg    <= '0;
            break_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            rover_reg   <= rover_next;
            heap_reg    <= heap_next;
            break_reg   <= break_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        if (cmd.load) begin
            op_reg    <= s_op;
            req_reg   <= s_num_bytes;
            faddr_reg <= s_free_address;
        end
        if (cmd.grow) begin
            new_break_reg <= (room < need) ? (BRK_W'(break_reg) + grow) : BRK_W'(break_reg);
        end
        if (cmd.out_load) begin
            m_data_address_reg <= res_addr_reg;
            m_status_reg       <= res_status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd) begin
            rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_data_address = m_data_address_reg;
    assign m_status       = m_status_reg;

endmodule

// ----- hw/rtl/nfba_ctrl.sv -----
// Allocator controller: sequences request capture, table scans, append and result transfer.
// Depends on nfba_pkg; commands nfba_datapath through cmd_t and reads sts_t.
module nfba_ctrl import nfba_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_A_RD     = 4'd2;
    localparam logic [3:0] S_A_CHK    = 4'd3;
    localparam logic [3:0] S_GROW     = 4'd4;
    localparam logic [3:0] S_APPEND   = 4'd5;
    localparam logic [3:0] S_F_RD     = 4'd6;
    localparam logic [3:0] S_F_CHK    = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    logic [3:0] state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (sts.op)
                    OP_ALLOC: begin
                        cmd.start_alloc = 1'b1;
                        state_next      = S_A_RD;
                    end
                    OP_FREE: begin
                        cmd.start_free = 1'b1;
                        state_next     = S_F_RD;
                    end
                    OP_RESET: begin
                        cmd.clear_heap = 1'b1;
                        cmd.res_ok     = 1'b1;
                        state_next     = S_DONE;
                    end
                    default: begin
                        cmd.res_ok = 1'b1;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_A_RD: begin
                if (sts.in_range) begin
                    cmd.rd     = 1'b1;
                    state_next = S_A_CHK;
                end else begin
                    state_next = S_GROW;
                end
            end
            S_A_CHK: begin
                if (sts.fit) begin
                    cmd.take   = 1'b1;
                    state_next = S_DONE;
                end else begin
                    cmd.next   = 1'b1;
                    state_next = S_A_RD;
                end
            end
            S_GROW: begin
                cmd.grow   = 1'b1;
                state_next = S_APPEND;
            end
            S_APPEND: begin
                cmd.append = 1'b1;
                state_next = S_DONE;
            end
            S_F_RD: begin
                if (sts.in_range) begin
                    cmd.rd     = 1'b1;
                    state_next = S_F_CHK;
                end else begin
                    cmd.res_unknown = 1'b1;
                    state_next      = S_DONE;
                end
            end
            S_F_CHK: begin
                if (sts.match) begin
                    cmd.release_blk = 1'b1;
                    state_next      = S_DONE;
                end else begin
                    cmd.next   = 1'b1;
                    state_next = S_F_RD;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
